// ----- hw/rtl/jcam_pkg.sv -----
// Package for the joint contact and arrival monitor.
// Holds payload structs, command kinds, register indexes and the debounce step.
// No dependencies.
package jcam_pkg;

    localparam int CNT_W = 6;
    localparam int TOL_W = 15;
    localparam int THR_W = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CNT_W-1:0] CUR_LIMIT_RESET = 6'd30;
    localparam logic [CNT_W-1:0] PID_LIMIT_RESET = 6'd10;
    localparam logic [TOL_W-1:0] TOL_RESET = 15'd16;
    localparam logic [THR_W-1:0] CUR_THR_RESET = 15'd30;
    localparam logic [THR_W-1:0] PID_THR_RESET = 15'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_CUR_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PID_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL = 2'd2;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_THRESH = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [3:0]        joint_index;
        logic signed [15:0] motor_current;
        logic signed [15:0] pid_error;
        logic signed [15:0] position;
        logic signed [15:0] target_position;
        logic signed [15:0] velocity_command;
        logic [14:0]       new_current_threshold;
        logic [14:0]       new_pid_threshold;
    } t_in;

    typedef struct packed {
        logic [3:0] joint_echo;
        logic       current_contact;
        logic       pid_contact;
        logic       collision;
        logic       arrived;
        logic       stop_joint;
    } t_out;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_THRESH,
        KIND_SKIP
    } t_kind;

    // Classified item handed from the front to the back.
    typedef struct packed {
        t_kind              kind;
        logic [3:0]         joint;
        logic signed [15:0] current;
        logic [16:0]        pid_mag;
        logic               arrived;
        logic [THR_W-1:0]   cur_thr;
        logic [THR_W-1:0]   pid_thr;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             flag;
    } t_deb;

    function automatic t_deb debounce_step(input logic above, input logic below,
                                           input logic [CNT_W-1:0] limit,
                                           input t_deb cur);
        t_deb nxt;
        nxt = cur;
        if (above && !cur.flag) begin
            if (cur.count >= limit) begin
                nxt.flag = 1'b1;
            end else begin
                nxt.count = cur.count + 1'b1;
            end
        end else if (below && cur.flag) begin
            if (cur.count == '0) begin
                nxt.flag = 1'b0;
            end else begin
                nxt.count = cur.count - 1'b1;
            end
        end
        return nxt;
    endfunction

endpackage

// ----- hw/rtl/joint_contact_and_arrival_monitor.sv -----
// Joint contact and arrival monitor, top level.
// An item is registered in the middle queue and again in the result queue before output.
// Throughput: one item per cycle while the result queue has room, set by the back end.
// Reset: all contact flags and debounce counts clear, thresholds return to 30 and 10,
// registers return to their defaults and both queues empty. Depends on jcam_pkg,
// jcam_front, jcam_queue and jcam_back.
module joint_contact_and_arrival_monitor #(
    parameter int JOINTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  jcam_pkg::t_in                     i_in,
    output logic                              empty,
    input  logic                              pop,
    output jcam_pkg::t_out                    o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [jcam_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [jcam_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import jcam_pkg::*;

    localparam int QDEPTH = 2;

    logic [CNT_W-1:0] r_cur_limit, r_pid_limit;
    logic [TOL_W-1:0] r_pos_tol;

    t_cmd  front_cmd, mid_cmd;
    logic  mid_empty, mid_take;
    t_out  back_res;
    logic  res_push, res_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_limit <= CUR_LIMIT_RESET;
            r_pid_limit <= PID_LIMIT_RESET;
            r_pos_tol   <= TOL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CUR_LIMIT: r_cur_limit <= i_cfg_data[CNT_W-1:0];
                CFG_PID_LIMIT: r_pid_limit <= i_cfg_data[CNT_W-1:0];
                CFG_POS_TOL:   r_pos_tol   <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    jcam_front #(.JOINTS(JOINTS)) u_front (
        .i_in      (i_in),
        .i_pos_tol (r_pos_tol),
        .o_cmd     (front_cmd)
    );

    jcam_queue #(.T(t_cmd), .DEPTH(QDEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (mid_take),
        .o_data  (mid_cmd),
        .o_empty (mid_empty)
    );

    jcam_back #(.JOINTS(JOINTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (mid_cmd),
        .i_cmd_valid (!mid_empty),
        .o_cmd_take  (mid_take),
        .i_cur_limit (r_cur_limit),
        .i_pid_limit (r_pid_limit),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    jcam_queue #(.T(t_out), .DEPTH(QDEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );

endmodule

// ----- hw/rtl/jcam_queue.sv -----
// Small first-in first-out queue of registers for any payload type.
// Depends on nothing; the payload type comes in as a parameter.
module jcam_queue #(
    parameter type T = logic,
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/jcam_front.sv -----
// Front end: classifies each input item and works out arrival and PID magnitude.
// Depends on jcam_pkg.
module jcam_front #(
    parameter int JOINTS = 16
) (
    input  jcam_pkg::t_in                      i_in,
    input  logic [jcam_pkg::TOL_W-1:0]         i_pos_tol,
    output jcam_pkg::t_cmd                     o_cmd
);
    import jcam_pkg::*;

    logic signed [16:0] err, tol, neg_tol;
    logic               in_tol, overshoot, in_range;

    always_comb begin
        err     = $signed({i_in.target_position[15], i_in.target_position})
                - $signed({i_in.position[15], i_in.position});
        tol     = $signed({2'b00, i_pos_tol});
        neg_tol = -tol;
        in_tol    = (err <= tol) && (err >= neg_tol);
        overshoot = ((err < 0) && (i_in.velocity_command > 0))
                 || ((err > 0) && (i_in.velocity_command < 0));
        in_range  = (32'(i_in.joint_index) < JOINTS);

        o_cmd.joint   = i_in.joint_index;
        o_cmd.current = i_in.motor_current;
        o_cmd.pid_mag = i_in.pid_error[15]
                      ? 17'(-$signed({1'b1, i_in.pid_error}))
                      : {1'b0, i_in.pid_error};
        o_cmd.arrived = in_tol || overshoot;
        o_cmd.cur_thr = i_in.new_current_threshold;
        o_cmd.pid_thr = i_in.new_pid_threshold;
        if (!in_range) begin
            o_cmd.kind = KIND_SKIP;
        end else if (i_in.req_type == REQ_THRESH) begin
            o_cmd.kind = KIND_THRESH;
        end else begin
            o_cmd.kind = KIND_SAMPLE;
        end
    end

endmodule

// ----- hw/rtl/jcam_back.sv -----
// Back end: per-joint debounce state and thresholds, one read-modify-write a cycle while the result side is not full.
// Depends on jcam_pkg.
module jcam_back #(
    parameter int JOINTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  jcam_pkg::t_cmd               i_cmd,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_take,
    input  logic [jcam_pkg::CNT_W-1:0]   i_cur_limit,
    input  logic [jcam_pkg::CNT_W-1:0]   i_pid_limit,
    output jcam_pkg::t_out               o_res,
    output logic                         o_res_push,
    input  logic                         i_res_full
);
    import jcam_pkg::*;

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    t_deb           r_cur_deb [JOINTS];
    t_deb           r_pid_deb [JOINTS];
    logic [THR_W-1:0] r_cur_thr [JOINTS];
    logic [THR_W-1:0] r_pid_thr [JOINTS];

    logic [JW-1:0]  idx;
    logic           go;
    logic           cur_above, cur_below, pid_above, pid_below;
    logic signed [16:0] cur_x, cur_thr_x;
    logic [16:0]    pid_thr_x;
    t_deb           cur_old, pid_old, n_cur_deb, n_pid_deb;

    assign idx        = JW'(i_cmd.joint);
    assign go         = i_cmd_valid && !i_res_full;
    assign o_cmd_take = go;
    assign o_res_push = go;

    always_comb begin
        cur_old   = r_cur_deb[idx];
        pid_old   = r_pid_deb[idx];
        cur_x     = $signed({i_cmd.current[15], i_cmd.current});
        cur_thr_x = $signed({2'b00, r_cur_thr[idx]});
        pid_thr_x = {2'b00, r_pid_thr[idx]};
        cur_above = cur_x > cur_thr_x;
        cur_below = cur_x < cur_thr_x;
        pid_above = i_cmd.pid_mag > pid_thr_x;
        pid_below = i_cmd.pid_mag < pid_thr_x;
        n_cur_deb = debounce_step(cur_above, cur_below, i_cur_limit, cur_old);
        n_pid_deb = debounce_step(pid_above, pid_below, i_pid_limit, pid_old);

        o_res.joint_echo = i_cmd.joint;
        case (i_cmd.kind)
            KIND_SAMPLE: begin
                o_res.current_contact = n_cur_deb.flag;
                o_res.pid_contact     = n_pid_deb.flag;
                o_res.arrived         = i_cmd.arrived;
            end
            KIND_THRESH: begin
                o_res.current_contact = cur_old.flag;
                o_res.pid_contact     = pid_old.flag;
                o_res.arrived         = 1'b0;
            end
            default: begin
                o_res.current_contact = 1'b0;
                o_res.pid_contact     = 1'b0;
                o_res.arrived         = 1'b0;
            end
        endcase
        o_res.collision  = o_res.current_contact | o_res.pid_contact;
        o_res.stop_joint = o_res.collision | o_res.arrived;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < JOINTS; j++) begin
                r_cur_deb[j] <= '0;
                r_pid_deb[j] <= '0;
                r_cur_thr[j] <= CUR_THR_RESET;
                r_pid_thr[j] <= PID_THR_RESET;
            end
        end else if (go) begin
            case (i_cmd.kind)
                KIND_SAMPLE: begin
                    r_cur_deb[idx] <= n_cur_deb;
                    r_pid_deb[idx] <= n_pid_deb;
                end
                KIND_THRESH: begin
                    r_cur_thr[idx] <= i_cmd.cur_thr;
                    r_pid_thr[idx] <= i_cmd.pid_thr;
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/jcam_checker.sv -----
// Port-level checks for the joint contact and arrival monitor, bound to the top level.
// Depends on jcam_pkg and joint_contact_and_arrival_monitor.
module jcam_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            push,
    input logic            full,
    input logic            empty,
    input logic            pop,
    input jcam_pkg::t_out  o_out
);
    import jcam_pkg::*;

    logic [3:0] r_pending;
    logic       in_xfer, out_xfer;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    // Track items transferred in whose results have not yet transferred out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {3'b000, in_xfer} - {3'b000, out_xfer};
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_pending != 4'd0))
        else $error("result shown with no item outstanding");

    a_full_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (r_pending >= 4'd2))
        else $error("full raised with too few items outstanding");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("waiting result changed or vanished");

endmodule

bind joint_contact_and_arrival_monitor jcam_checker u_jcam_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);
